>>> hw/rtl/scc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Shared widths, reset values and the walker status bundle of the strongly
// connected component counter.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int ROW_INDEX_W = 4;
    localparam int ROW_EDGES_W = 16;
    localparam int CFG_W       = 5;
    localparam int COUNT_W     = 5;

    localparam logic [CFG_W-1:0]   NODES_IN_USE_RESET = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX          = 5'd31;

    // Status that the walker reports to the top level.
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [COUNT_W-1:0] count;
    } walk_status_t;

endpackage

>>> hw/rtl/scc_adj_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_adj_store
// Adjacency matrix memory: one row written per loaded word, one row read
// per cycle with registered read data.
// ----------------------------------------------------------------------------
module scc_adj_store #(
    parameter int NODES = 16
) (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [scc_pkg::ROW_INDEX_W-1:0]     wr_index,
    input  logic [scc_pkg::ROW_EDGES_W-1:0]     wr_edges,
    input  logic [$clog2(NODES)-1:0]            rd_addr,
    output logic [NODES-1:0]                    rd_data
);
    import scc_pkg::*;

    localparam int VW = $clog2(NODES);

    logic [NODES-1:0] adj_mem [NODES];
    logic [NODES-1:0] rd_data_reg;
    logic             row_in_range;
    logic [VW-1:0]    wr_addr;
    logic [NODES-1:0] wr_row;

    // Rows beyond the matrix are dropped; edge bits are zero-extended or cut.
    assign row_in_range = 32'(wr_index) < 32'(NODES);
    assign wr_addr      = VW'(wr_index);
    assign wr_row       = NODES'(wr_edges);

    always_ff @(posedge aclk) begin
        if (wr_en && row_in_range) begin
            adj_mem[wr_addr] <= wr_row;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= adj_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/scc_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_walker
// Sequencer for both depth-first passes. Each candidate neighbor is read
// in ST_READ and tested in ST_TEST through the single adjacency read port;
// the walk stack and the finishing order live in small memories.
// ----------------------------------------------------------------------------
module scc_walker #(
    parameter int NODES = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [$clog2(NODES+1)-1:0]     nodes_n,
    input  logic                           out_free,
    output logic [$clog2(NODES)-1:0]       adj_raddr,
    input  logic [NODES-1:0]               adj_rdata,
    output scc_pkg::walk_status_t          status
);
    import scc_pkg::*;

    localparam int VW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam int SW = VW + CW;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_OUTER   = 8'b0000_0010,
        ST_READ    = 8'b0000_0100,
        ST_TEST    = 8'b0000_1000,
        ST_RESTORE = 8'b0001_0000,
        ST_KFETCH  = 8'b0010_0000,
        ST_KTEST   = 8'b0100_0000,
        ST_DONE    = 8'b1000_0000
    } walk_state_t;

    walk_state_t        state_reg, state_next;
    logic [VW-1:0]      vertex_reg, vertex_next;
    logic [CW-1:0]      scan_reg, scan_next;
    logic [CW-1:0]      depth_reg, depth_next;
    logic [CW-1:0]      outer_reg, outer_next;
    logic [CW-1:0]      fin_cnt_reg, fin_cnt_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [NODES-1:0]   visited_reg, visited_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic               transposed_reg, transposed_next;

    logic [SW-1:0]      stk_mem [NODES];
    logic [SW-1:0]      stk_rdata_reg;
    logic               stk_we;
    logic [VW-1:0]      stk_waddr;
    logic [SW-1:0]      stk_wdata;
    logic [VW-1:0]      stk_raddr;

    logic [VW-1:0]      fo_mem [NODES];
    logic [VW-1:0]      fo_rdata_reg;
    logic               fo_we;
    logic [VW-1:0]      fo_waddr;
    logic [VW-1:0]      fo_raddr;

    logic               edge_bit;

    assign edge_bit = transposed_reg ? adj_rdata[vertex_reg] : adj_rdata[scan_reg[VW-1:0]];

    always_comb begin
        state_next      = state_reg;
        vertex_next     = vertex_reg;
        scan_next       = scan_reg;
        depth_next      = depth_reg;
        outer_next      = outer_reg;
        fin_cnt_next    = fin_cnt_reg;
        k_next          = k_reg;
        n_next          = n_reg;
        visited_next    = visited_reg;
        total_next      = total_reg;
        transposed_next = transposed_reg;
        stk_we          = 1'b0;
        stk_waddr       = '0;
        stk_wdata       = '0;
        stk_raddr       = '0;
        fo_we           = 1'b0;
        fo_waddr        = '0;
        fo_raddr        = '0;
        adj_raddr       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    n_next          = nodes_n;
                    visited_next    = '0;
                    fin_cnt_next    = '0;
                    total_next      = '0;
                    outer_next      = '0;
                    depth_next      = '0;
                    transposed_next = 1'b0;
                    state_next      = ST_OUTER;
                end
            end
            ST_OUTER: begin
                if (outer_reg == n_reg) begin
                    // First pass complete: replay finishing order backward.
                    visited_next    = '0;
                    k_next          = fin_cnt_reg;
                    transposed_next = 1'b1;
                    state_next      = ST_KFETCH;
                end else if (visited_reg[outer_reg[VW-1:0]]) begin
                    outer_next = outer_reg + CW'(1);
                end else begin
                    visited_next[outer_reg[VW-1:0]] = 1'b1;
                    vertex_next = outer_reg[VW-1:0];
                    scan_next   = '0;
                    depth_next  = CW'(1);
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                if (scan_reg < n_reg) begin
                    adj_raddr  = transposed_reg ? scan_reg[VW-1:0] : vertex_reg;
                    state_next = ST_TEST;
                end else begin
                    // Top vertex has no unvisited neighbor left: it finishes.
                    if (!transposed_reg && (fin_cnt_reg < CW'(NODES))) begin
                        fo_we        = 1'b1;
                        fo_waddr     = fin_cnt_reg[VW-1:0];
                        fin_cnt_next = fin_cnt_reg + CW'(1);
                    end
                    depth_next = depth_reg - CW'(1);
                    if (depth_reg == CW'(1)) begin
                        state_next = transposed_reg ? ST_KFETCH : ST_OUTER;
                    end else begin
                        stk_raddr  = VW'(depth_reg - CW'(2));
                        state_next = ST_RESTORE;
                    end
                end
            end
            ST_TEST: begin
                if (edge_bit && !visited_reg[scan_reg[VW-1:0]] &&
                    (depth_reg < CW'(NODES))) begin
                    stk_we      = 1'b1;
                    stk_waddr   = VW'(depth_reg - CW'(1));
                    stk_wdata   = {vertex_reg, scan_reg + CW'(1)};
                    visited_next[scan_reg[VW-1:0]] = 1'b1;
                    vertex_next = scan_reg[VW-1:0];
                    scan_next   = '0;
                    depth_next  = depth_reg + CW'(1);
                end else begin
                    scan_next = scan_reg + CW'(1);
                end
                state_next = ST_READ;
            end
            ST_RESTORE: begin
                {vertex_next, scan_next} = stk_rdata_reg;
                state_next = ST_READ;
            end
            ST_KFETCH: begin
                if (k_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    fo_raddr   = VW'(k_reg - CW'(1));
                    k_next     = k_reg - CW'(1);
                    state_next = ST_KTEST;
                end
            end
            ST_KTEST: begin
                if ((CW'(fo_rdata_reg) < n_reg) && !visited_reg[fo_rdata_reg]) begin
                    visited_next[fo_rdata_reg] = 1'b1;
                    vertex_next = fo_rdata_reg;
                    scan_next   = '0;
                    depth_next  = CW'(1);
                    if (total_reg != COUNT_MAX) begin
                        total_next = total_reg + COUNT_W'(1);
                    end
                    state_next = ST_READ;
                end else begin
                    state_next = ST_KFETCH;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            depth_reg      <= '0;
            outer_reg      <= '0;
            fin_cnt_reg    <= '0;
            k_reg          <= '0;
            visited_reg    <= '0;
            total_reg      <= '0;
            transposed_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            depth_reg      <= depth_next;
            outer_reg      <= outer_next;
            fin_cnt_reg    <= fin_cnt_next;
            k_reg          <= k_next;
            visited_reg    <= visited_next;
            total_reg      <= total_next;
            transposed_reg <= transposed_next;
        end
    end

    always_ff @(posedge aclk) begin
        vertex_reg <= vertex_next;
        scan_reg   <= scan_next;
        n_reg      <= n_next;
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rdata_reg <= stk_mem[stk_raddr];
    end

    always_ff @(posedge aclk) begin
        if (fo_we) begin
            fo_mem[fo_waddr] <= vertex_reg;
        end
        fo_rdata_reg <= fo_mem[fo_raddr];
    end

    assign status.busy  = (state_reg != ST_IDLE);
    assign status.done  = (state_reg == ST_DONE) && out_free;
    assign status.count = total_reg;

endmodule

>>> hw/rtl/scc_counter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_counter_top
// Strongly connected component counter (Kosaraju). Adjacency rows load one
// word per cycle while no run is in progress; the final row starts two
// depth-first passes and the count is delivered as one result word.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  s_      | s_valid / s_ready  | s_row_index, s_row_edges, s_last_row
//  m_      | m_valid / m_ready  | m_component_count
//  cfg_    | cfg_wr_en          | cfg_wr_data (nodes in use)
//
// A row word without the last-row flag is taken without starting a run.
// A word with the flag starts a run; each candidate neighbor is read
// through the single adjacency read port, once per pass.
// s_ready stays low during a run; a finished count waits in the output
// register, and the next run holds its result until that register is free.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module scc_counter_top #(
    parameter int NODES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [scc_pkg::ROW_INDEX_W-1:0]   s_row_index,
    input  logic [scc_pkg::ROW_EDGES_W-1:0]   s_row_edges,
    input  logic                              s_last_row,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [scc_pkg::COUNT_W-1:0]       m_component_count,
    input  logic                              cfg_wr_en,
    input  logic [scc_pkg::CFG_W-1:0]         cfg_wr_data
);
    import scc_pkg::*;

    localparam int VW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);

    logic [CFG_W-1:0]   nodes_in_use_reg;
    logic [CW-1:0]      nodes_eff;
    logic               m_valid_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               s_accept;
    logic               run_start;
    logic               out_free;
    logic [VW-1:0]      adj_raddr;
    logic [NODES-1:0]   adj_rdata;
    walk_status_t       walk_status;

    assign s_ready   = !walk_status.busy;
    assign s_accept  = s_valid && s_ready;
    assign run_start = s_accept && s_last_row;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        if (nodes_in_use_reg == '0) begin
            nodes_eff = CW'(1);
        end else if (32'(nodes_in_use_reg) > 32'(NODES)) begin
            nodes_eff = CW'(NODES);
        end else begin
            nodes_eff = CW'(nodes_in_use_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nodes_in_use_reg <= NODES_IN_USE_RESET;
        end else if (cfg_wr_en) begin
            nodes_in_use_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (walk_status.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (walk_status.done) begin
            count_reg <= walk_status.count;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_component_count = count_reg;

    scc_adj_store #(
        .NODES (NODES)
    ) u_adj_store (
        .aclk     (aclk),
        .wr_en    (s_accept),
        .wr_index (s_row_index),
        .wr_edges (s_row_edges),
        .rd_addr  (adj_raddr),
        .rd_data  (adj_rdata)
    );

    scc_walker #(
        .NODES (NODES)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (run_start),
        .nodes_n   (nodes_eff),
        .out_free  (out_free),
        .adj_raddr (adj_raddr),
        .adj_rdata (adj_rdata),
        .status    (walk_status)
    );

    // A final row always starts a run, so no word is taken next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        run_start |=> !s_ready)
        else $error("input accepted right after a final row");

    // Plain row words never stall the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !s_last_row) |=> s_ready)
        else $error("row load left the block busy");

    // A new result appears only at the end of a run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(walk_status.busy))
        else $error("result appeared without a run");

    // A count never exceeds the number of vertices.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_component_count) <= 32'(NODES)))
        else $error("component count out of range");

endmodule

>>> tb/sv/scc_count_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_count_checker
// Watches the row, result and register ports of the component counter. It
// keeps its own copy of the adjacency rows and the vertex count, works out
// the component count for every final row word, and compares each delivered
// count with the oldest one still owed.
// ----------------------------------------------------------------------------
module scc_count_checker #(
    parameter int NODES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [scc_pkg::ROW_INDEX_W-1:0]   s_row_index,
    input  logic [scc_pkg::ROW_EDGES_W-1:0]   s_row_edges,
    input  logic                              s_last_row,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [scc_pkg::COUNT_W-1:0]       m_component_count,
    input  logic                              cfg_wr_en,
    input  logic [scc_pkg::CFG_W-1:0]         cfg_wr_data,
    output int                                failures,
    output int                                pending
);

    logic [scc_pkg::ROW_EDGES_W-1:0] graph_rows [NODES];
    logic [scc_pkg::CFG_W-1:0]       nodes_cfg;
    logic [NODES-1:0]                walk_seen;
    int unsigned                     finish_list[$];
    logic [scc_pkg::COUNT_W-1:0]     owed_counts[$];
    int                              fail_total = 0;

    // Iterative depth-first walk. The transposed walk reads the matrix by
    // columns; the forward walk records vertices as they finish.
    function automatic void walk_graph(int unsigned root, int unsigned n, bit transposed,
                                       bit record);
        int unsigned vtx [NODES];
        int unsigned nxt [NODES];
        int unsigned depth;
        int unsigned j;
        int unsigned top_v;
        bit          linked;
        walk_seen[root] = 1'b1;
        vtx[0] = root;
        nxt[0] = 0;
        depth = 1;
        while (depth > 0) begin
            top_v = vtx[depth-1];
            j = nxt[depth-1];
            while (j < n) begin
                linked = transposed ? graph_rows[j][top_v] : graph_rows[top_v][j];
                if (linked && !walk_seen[j])
                    break;
                j++;
            end
            if (j < n && depth < NODES) begin
                nxt[depth-1] = j + 1;
                walk_seen[j] = 1'b1;
                vtx[depth] = j;
                nxt[depth] = 0;
                depth++;
            end else begin
                if (record && finish_list.size() < NODES)
                    finish_list.push_back(top_v);
                depth--;
            end
        end
    endfunction

    function automatic logic [scc_pkg::COUNT_W-1:0] count_components(int unsigned n);
        int unsigned total;
        int unsigned v;
        walk_seen = '0;
        finish_list.delete();
        for (v = 0; v < n; v++)
            if (!walk_seen[v])
                walk_graph(v, n, 1'b0, 1'b1);
        walk_seen = '0;
        total = 0;
        for (int k = finish_list.size(); k > 0; k--) begin
            v = finish_list[k-1];
            if (v < n && !walk_seen[v]) begin
                walk_graph(v, n, 1'b1, 1'b0);
                total++;
            end
        end
        if (total > scc_pkg::COUNT_MAX)
            return scc_pkg::COUNT_MAX;
        return scc_pkg::COUNT_W'(total);
    endfunction

    always @(posedge aclk) begin : watch
        int unsigned                 n;
        logic [scc_pkg::COUNT_W-1:0] want;
        if (!aresetn) begin
            nodes_cfg = scc_pkg::NODES_IN_USE_RESET;
            owed_counts.delete();
        end else begin
            if (cfg_wr_en)
                nodes_cfg = cfg_wr_data;
            if (s_valid && s_ready) begin
                if (s_row_index < NODES)
                    graph_rows[s_row_index] = s_row_edges;
                if (s_last_row) begin
                    // A count of zero behaves as one vertex, anything above the
                    // matrix size as the full matrix.
                    n = (nodes_cfg == 0) ? 1 : ((nodes_cfg > NODES) ? NODES : nodes_cfg);
                    owed_counts.push_back(count_components(n));
                end
            end
            if (m_valid && m_ready) begin
                if (owed_counts.size() == 0) begin
                    $error("m_component_count: expected none, actual %0d", m_component_count);
                    fail_total++;
                end else begin
                    want = owed_counts.pop_front();
                    if (m_component_count !== want) begin
                        $error("m_component_count: expected %0d, actual %0d",
                               want, m_component_count);
                        fail_total++;
                    end
                end
            end
        end
        failures <= fail_total;
        pending  <= owed_counts.size();
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives adjacency rows and vertex-count settings into the component
// counter, a few hand-picked graphs first and then random graphs under
// varying back-pressure, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NODES          = 16;
    localparam int ITEM_TARGET    = 2000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int END_CYCLES     = 1200;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic [scc_pkg::ROW_INDEX_W-1:0]   s_row_index;
    logic [scc_pkg::ROW_EDGES_W-1:0]   s_row_edges;
    logic                              s_last_row;
    logic                              m_valid;
    logic                              m_ready;
    logic [scc_pkg::COUNT_W-1:0]       m_component_count;
    logic                              cfg_wr_en;
    logic [scc_pkg::CFG_W-1:0]         cfg_wr_data;

    int          check_failures;
    int          counts_pending;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          items_sent = 0;
    int unsigned graph_size = NODES;
    logic [NODES-1:0] rows_loaded = '0;
    logic        hold_flip;
    int          quiet_cycles = 0;

    scc_counter_top #(
        .NODES(NODES)
    ) DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_row_index       (s_row_index),
        .s_row_edges       (s_row_edges),
        .s_last_row        (s_last_row),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_component_count (m_component_count),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data)
    );

    scc_count_checker #(
        .NODES(NODES)
    ) count_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_row_index       (s_row_index),
        .s_row_edges       (s_row_edges),
        .s_last_row        (s_last_row),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_component_count (m_component_count),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .failures          (check_failures),
        .pending           (counts_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: random stalls, plus one long hold-off started by a toggle
    // of hold_flip.
    initial begin : result_sink
        bit          hold_seen;
        int unsigned hold_left;
        hold_seen = 1'b0;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_flip != hold_seen) begin
                hold_seen = hold_flip;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [scc_pkg::ROW_EDGES_W-1:0] random_edges(int unsigned n);
        case ($urandom_range(5))
            0: return 16'($urandom & $urandom & $urandom);
            1: return 16'($urandom & $urandom);
            2: return 16'($urandom);
            3: return 16'(1 << $urandom_range(n - 1)) | 16'($urandom & $urandom & $urandom);
            4: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic send_row(input int unsigned row, input logic [15:0] edges,
                            input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_row_index <= scc_pkg::ROW_INDEX_W'(row);
        s_row_edges <= edges;
        s_last_row  <= last;
        do @(posedge aclk); while (!s_ready);
        rows_loaded[row] = 1'b1;
        items_sent++;
    endtask

    task automatic wait_for_counts();
        s_valid <= 1'b0;
        do @(posedge aclk); while (counts_pending != 0);
    endtask

    task automatic write_nodes(input int unsigned value);
        wait_for_counts();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= scc_pkg::CFG_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        graph_size = (value == 0) ? 1 : ((value > NODES) ? NODES : value);
    endtask

    // Loads every row in use in shuffled order, the last one flagged, with a
    // few rows outside the graph mixed in.
    task automatic send_graph(input int unsigned n);
        int unsigned order [NODES];
        int unsigned pick;
        int unsigned swap;
        for (int i = 0; i < n; i++)
            order[i] = i;
        for (int i = n - 1; i > 0; i--) begin
            pick = $urandom_range(i);
            swap = order[i];
            order[i] = order[pick];
            order[pick] = swap;
        end
        for (int i = 0; i < n; i++) begin
            if (n < NODES && $urandom_range(7) == 0)
                send_row($urandom_range(NODES - 1, n), random_edges(n), 1'b0);
            send_row(order[i], random_edges(n), i == n - 1);
        end
    endtask

    initial begin : stimulus
        int unsigned      choice;
        int unsigned      idx;
        int               target;
        logic [NODES-1:0] in_use;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_row_index <= '0;
        s_row_edges <= '0;
        s_last_row  <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        hold_flip   <= 1'b0;
        tx_idle_pct = 30;
        rx_idle_pct = 48;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Complete graph at the reset vertex count, then one vertex cut off.
        for (int r = 0; r < NODES; r++)
            send_row(r, 16'hFFFF, r == NODES - 1);
        send_row(7, 16'h0000, 1'b1);
        // A count of zero behaves as one vertex; a flagged row outside the
        // graph still starts a count.
        write_nodes(0);
        send_row(0, 16'hFFFF, 1'b1);
        send_row(15, 16'h0000, 1'b1);
        // Two-vertex cycle, then broken by rewriting one row alone.
        write_nodes(2);
        send_row(0, 16'h0002, 1'b0);
        send_row(1, 16'h0001, 1'b1);
        send_row(1, 16'h0000, 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 30;
                    rx_idle_pct = 48;
                    write_nodes(1);
                end
                1: begin
                    tx_idle_pct = 48;
                    rx_idle_pct = 30;
                    write_nodes(NODES);
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    write_nodes(31);
                    send_graph(graph_size);
                    // Hold results back while small graphs keep coming, so the
                    // counter fills up and stops taking rows.
                    write_nodes(3);
                    hold_flip <= ~hold_flip;
                    repeat (4) send_graph(graph_size);
                end
            endcase
            target = 22 + ITEM_TARGET * (phase + 1) / 3;
            while (items_sent < target) begin
                if ($urandom_range(5) == 0) begin
                    choice = $urandom_range(99);
                    if (choice < 55)
                        write_nodes($urandom_range(6, 1));
                    else if (choice < 80)
                        write_nodes($urandom_range(12, 7));
                    else if (choice < 92)
                        write_nodes($urandom_range(16, 13));
                    else if (choice < 96)
                        write_nodes(0);
                    else
                        write_nodes($urandom_range(31, 17));
                end
                choice = $urandom_range(9);
                if (choice < 8) begin
                    send_graph(graph_size);
                end else if (choice == 8) begin
                    repeat ($urandom_range(4, 1))
                        send_row($urandom_range(NODES - 1), random_edges(graph_size), 1'b0);
                end else begin
                    // Recount with one row replaced, only when the whole graph
                    // in use has been loaded before.
                    idx = $urandom_range(NODES - 1);
                    in_use = NODES'((17'd1 << graph_size) - 17'd1);
                    if (((rows_loaded | (NODES'(1) << idx)) & in_use) == in_use)
                        send_row(idx, random_edges(graph_size), 1'b1);
                end
            end
        end

        wait_for_counts();
        repeat (END_CYCLES) @(posedge aclk);
        if (check_failures == 0 && counts_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
